// File: hw/rtl/earliest_fit_job_shop_scheduler_unit_assert.svh
// Assertion macros for the earliest-fit scheduler.
// Used by the checker module; no other dependencies.
`ifndef EARLIEST_FIT_JOB_SHOP_SCHEDULER_UNIT_ASSERT_SVH
`define EARLIEST_FIT_JOB_SHOP_SCHEDULER_UNIT_ASSERT_SVH

// implication checked on every clock, off during reset
`define EFS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define EFS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// File: hw/rtl/efs_pkg.sv
// Package for the earliest-fit scheduler: sizes, opcodes, result record.
// No dependencies.
`default_nettype none
package efs_pkg;
	localparam int DEF_MAX_JOBS     = 32;
	localparam int DEF_MAX_MACHINES = 32;
	localparam int DEF_MAX_STEPS    = 32;
	localparam int DEF_HORIZON      = 1024;

	localparam int FW = 5;
	localparam int TW = 11;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_SCHED = 1'b1;

	typedef struct packed {
		logic [9:0]  start_time;
		logic [10:0] end_time;
		logic [4:0]  machine_used;
		logic [10:0] makespan;
		logic        overflow;
	} efs_res_t;
endpackage
`default_nettype wire

// File: hw/rtl/efs_ram.sv
// Generic single-port-write, single-read synchronous RAM, registered read.
// No dependencies.
`default_nettype none
module efs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// File: hw/rtl/earliest_fit_job_shop_scheduler_unit.sv
// Earliest-fit job shop scheduler: top level with control sequencer.
// Depends on efs_pkg and efs_ram.
//
// Channels: s_axis_* takes requests, tdata = {duration, machine, step, job,
// operation} from bit 0 (operation) up; m_axis_* gives one result per schedule
// request, tdata = start_time, end_time, machine_used, makespan, overflow.
// A load request gives no result and leaves the block ready; loads can follow
// back to back.
// A schedule request reads the job state and route (ST_JRD, ST_RD, ST_RT),
// scans the machine timeline, checking each slot in ST_SCAN then ST_SWT from
// the job's ready time, then marks the chosen slots one per cycle and writes
// the job state back. The slot memory holds one bit per machine and slot.
// After reset a clearing pass zeroes the slot and job memories, one entry per
// cycle, with s_axis_tready low.
// A finished result sits in the output register; if the receiver stalls, the
// block still takes the next request and works on it until its own result
// is ready, then waits for the output register to free up.
`default_nettype none
module earliest_fit_job_shop_scheduler_unit
	import efs_pkg::*;
#(
	parameter int MAX_JOBS     = DEF_MAX_JOBS,
	parameter int MAX_MACHINES = DEF_MAX_MACHINES,
	parameter int MAX_STEPS    = DEF_MAX_STEPS,
	parameter int HORIZON      = DEF_HORIZON
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// operation, job, step, machine, duration; zero fill
	input  wire logic [23:0] s_axis_tdata,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// start_time, end_time, machine_used, makespan, overflow; zero fill
	output logic [39:0]      m_axis_tdata
);
	localparam int JW  = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
	localparam int JD  = (MAX_JOBS > 1) ? MAX_JOBS : 2;
	localparam int RD  = MAX_JOBS * MAX_STEPS;
	localparam int RAW = $clog2(RD > 1 ? RD : 2);
	localparam int SD  = MAX_MACHINES * HORIZON;
	localparam int SAW = $clog2(SD);
	localparam int PW  = SAW + 1;
	localparam int NSW = $clog2(MAX_STEPS + 1);
	localparam int TMW = $clog2(HORIZON + 1);
	localparam int CW  = TMW + 1;
	localparam int CLN = (SD > MAX_JOBS) ? SD : MAX_JOBS;
	localparam int CLW = $clog2(CLN);

	localparam logic [3:0] ST_CLR = 4'd0, ST_IDLE = 4'd1, ST_RD = 4'd2,
		ST_RT = 4'd3, ST_SCAN = 4'd4, ST_SWT = 4'd5, ST_MARK = 4'd6,
		ST_OUT = 4'd7, ST_JRD = 4'd8;

	logic [3:0]  state_q;
	logic        op;
	logic [4:0]  in_job, in_step, in_mach, in_dur;
	logic [JW-1:0] job_q;
	logic [CLW-1:0] clr_q;
	logic [4:0]  mach_q, dur_q;
	logic [CW-1:0] s_q, k_q, rdy_q;
	logic [TMW-1:0] latest_q;
	logic [NSW-1:0] nstep_q;
	efs_res_t    res_q;
	efs_res_t    out_q;
	logic        ovalid_q;

	assign op      = s_axis_tdata[0];
	assign in_job  = s_axis_tdata[5:1];
	assign in_step = s_axis_tdata[10:6];
	assign in_mach = s_axis_tdata[15:11];
	assign in_dur  = s_axis_tdata[20:16];

	// route memory: machine and duration packed
	logic          r_we;
	logic [RAW-1:0] r_wa, r_ra;
	logic [9:0]    r_rd;
	efs_ram #(.WIDTH(10), .DEPTH(RD > 1 ? RD : 2)) u_route (
		.clk(clk), .we(r_we), .waddr(r_wa), .wdata({in_dur, in_mach}),
		.raddr(r_ra), .rdata(r_rd));

	// job memory: next step and ready time
	logic          j_we;
	logic [JW-1:0] j_ra, j_wa;
	logic [NSW+TMW-1:0] j_wd, j_rd;
	efs_ram #(.WIDTH(NSW + TMW), .DEPTH(JD)) u_job (
		.clk(clk), .we(j_we), .waddr(j_wa), .wdata(j_wd),
		.raddr(j_ra), .rdata(j_rd));

	// slot memory
	logic           b_we, b_wd;
	logic [SAW-1:0] b_wa, b_ra;
	logic           b_rd;
	efs_ram #(.WIDTH(1), .DEPTH(SD)) u_slot (
		.clk(clk), .we(b_we), .waddr(b_wa), .wdata(b_wd),
		.raddr(b_ra), .rdata(b_rd));

	logic accept;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept = s_axis_tvalid && s_axis_tready;

	logic job_in_range, load_ok;
	assign job_in_range = ({4'b0, in_job} < 9'(MAX_JOBS));
	assign load_ok = job_in_range && ({4'b0, in_step} < 9'(MAX_STEPS))
		&& ({4'b0, in_mach} < 9'(MAX_MACHINES));

	logic [PW-1:0] slot_base;
	logic [CW-1:0] cur;
	logic [TMW-1:0] fin;
	assign slot_base = PW'(mach_q) * PW'(HORIZON);
	assign cur = s_q + k_q;
	assign fin = TMW'(s_q + CW'(dur_q));

	always_comb begin
		r_we = accept && op == OP_LOAD && load_ok;
		r_wa = RAW'(32'(in_job) * 32'(MAX_STEPS) + 32'(in_step));
		r_ra = RAW'(32'(job_q) * 32'(MAX_STEPS) + 32'(nstep_q));
		j_ra = JW'(in_job);
		j_we = 1'b0;
		j_wa = job_q;
		j_wd = {nstep_q + NSW'(1), fin};
		b_we = 1'b0;
		b_wd = 1'b1;
		b_wa = SAW'(slot_base + PW'(cur));
		b_ra = SAW'(slot_base + PW'(cur));
		unique case (state_q)
			ST_CLR: begin
				b_we = (32'(clr_q) < SD);
				b_wd = 1'b0;
				b_wa = SAW'(clr_q);
				j_we = (32'(clr_q) < MAX_JOBS);
				j_wa = JW'(clr_q);
				j_wd = '0;
			end
			ST_MARK: begin
				b_we = (k_q < CW'(dur_q));
				j_we = !(k_q < CW'(dur_q));
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLR;
			clr_q    <= '0;
			latest_q <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (state_q == ST_OUT && (!ovalid_q || m_axis_tready)) begin
				ovalid_q <= 1'b1;
			end else if (m_axis_tready) begin
				ovalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (32'(clr_q) == CLN - 1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept && op == OP_SCHED) begin
						job_q <= JW'(in_job);
						res_q <= '{10'd0, 11'd0, 5'd0, 11'(latest_q), 1'b1};
						state_q <= job_in_range ? ST_JRD : ST_OUT;
					end
				end
				ST_JRD: begin
					nstep_q <= j_rd[NSW+TMW-1:TMW];
					rdy_q <= CW'(j_rd[TMW-1:0]);
					state_q <= (32'(j_rd[NSW+TMW-1:TMW]) < MAX_STEPS) ? ST_RD : ST_OUT;
				end
				ST_RD: state_q <= ST_RT;
				ST_RT: begin
					mach_q <= r_rd[4:0];
					dur_q  <= r_rd[9:5];
					res_q.machine_used <= r_rd[4:0];
					s_q <= rdy_q;
					k_q <= '0;
					state_q <= (32'(r_rd[4:0]) < MAX_MACHINES) ? ST_SCAN : ST_OUT;
				end
				ST_SCAN: begin
					if (!(s_q < CW'(HORIZON)) || (s_q + CW'(dur_q) > CW'(HORIZON))) begin
						state_q <= ST_OUT;
					end else if (k_q == CW'(dur_q)) begin
						k_q <= '0;
						state_q <= ST_MARK;
					end else begin
						state_q <= ST_SWT;
					end
				end
				ST_SWT: begin
					if (b_rd) begin
						s_q <= cur + CW'(1);
						k_q <= '0;
					end else begin
						k_q <= k_q + CW'(1);
					end
					state_q <= ST_SCAN;
				end
				ST_MARK: begin
					if (k_q < CW'(dur_q)) begin
						k_q <= k_q + CW'(1);
					end else begin
						if (fin > latest_q) begin
							latest_q <= fin;
							res_q.makespan <= 11'(fin);
						end
						res_q.start_time <= 10'(s_q);
						res_q.end_time <= 11'(fin);
						res_q.overflow <= 1'b0;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!ovalid_q || m_axis_tready) begin
						out_q <= res_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata = {2'b0, out_q.overflow, out_q.makespan, out_q.machine_used,
		out_q.end_time, out_q.start_time};
endmodule
`default_nettype wire

// File: hw/rtl/efs_checker.sv
// Port-level checker for the earliest-fit scheduler, bound to the top level.
// Depends on earliest_fit_job_shop_scheduler_unit_assert.svh.
`default_nettype none
`include "earliest_fit_job_shop_scheduler_unit_assert.svh"
module efs_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tvalid,
	input wire logic        s_axis_tready,
	input wire logic [23:0] s_axis_tdata,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [39:0] m_axis_tdata
);
	logic [9:0]  res_start;
	logic [10:0] res_end, res_span;
	logic [20:0] res_low;
	logic        res_ovf;
	logic        sched_req;

	assign res_start = m_axis_tdata[9:0];
	assign res_end   = m_axis_tdata[20:10];
	assign res_span  = m_axis_tdata[36:26];
	assign res_ovf   = m_axis_tdata[37];
	assign res_low   = m_axis_tdata[20:0];
	assign sched_req = s_axis_tvalid && s_axis_tready && s_axis_tdata[0];

	`EFS_ASSERT_NEXT(a_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
	`EFS_ASSERT_IMPL(a_ovf_zero, clk, arst_n, m_axis_tvalid && res_ovf, res_low == 21'd0)
	`EFS_ASSERT_IMPL(a_end, clk, arst_n, m_axis_tvalid && !res_ovf, res_end >= {1'b0, res_start})
	`EFS_ASSERT_IMPL(a_span, clk, arst_n, m_axis_tvalid && !res_ovf, res_span >= res_end)
	`EFS_ASSERT_NEXT(a_sched_busy, clk, arst_n, sched_req, !s_axis_tready)
endmodule

bind earliest_fit_job_shop_scheduler_unit efs_checker u_efs_checker (.*);
`default_nettype wire
